/* rtl/uhs_pkg.sv */
// Shared types, constants and lookup functions of the UTF-8 homoglyph substituter.
`default_nettype none

package uhs_pkg;

  localparam int unsigned PROB_W    = 17;  // probability, 1.16 fixed point
  localparam int unsigned PROB_FRAC = 16;
  localparam int unsigned RUN_MAX   = 8;   // longest output run per item
  localparam int unsigned IDX_W     = 3;   // byte index within a run

  localparam logic [1:0] CFG_PROB_SPACE    = 2'd0;
  localparam logic [1:0] CFG_PROB_QUESTION = 2'd1;
  localparam logic [1:0] CFG_PROB_LETTER   = 2'd2;

  localparam logic [7:0] ZWSP_B0   = 8'he2;
  localparam logic [7:0] ZWSP_B1   = 8'h80;
  localparam logic [7:0] ZWSP_B2   = 8'h8b;
  localparam logic [7:0] GREEK_Q0  = 8'hcd;
  localparam logic [7:0] GREEK_Q1  = 8'hbe;
  localparam logic [7:0] SEMICOLON = 8'h3b;
  localparam logic [7:0] LATIN_A   = 8'h61;
  localparam logic [7:0] HIGH_BIT  = 8'b1000_0000;

  // One run of output bytes; byte 0 sits in the lowest bits.
  typedef struct packed {
    logic [RUN_MAX*8-1:0] bytes;
    logic [IDX_W-1:0]     last_idx;
  } run_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] hi;
    logic [7:0] lo;
  } letter_t;

  // Cyrillic look-alike of a Latin letter, as two UTF-8 bytes.
  function automatic letter_t letter_lookup(input logic [7:0] c);
    letter_t r;
    r.hit = 1'b1;
    r.hi  = 8'hd0;
    r.lo  = 8'h00;
    case (c)
      8'h61: r.lo = 8'hb0;               // a
      8'h41: r.lo = 8'h90;               // A
      8'h65: r.lo = 8'hb5;               // e
      8'h45: r.lo = 8'h95;               // E
      8'h54: r.lo = 8'ha2;               // T
      8'h6f: r.lo = 8'hbe;               // o
      8'h4f: r.lo = 8'h9e;               // O
      8'h78: begin r.hi = 8'hd1; r.lo = 8'h85; end  // x
      8'h58: r.lo = 8'ha5;               // X
      8'h79: begin r.hi = 8'hd1; r.lo = 8'h83; end  // y
      8'h4b: r.lo = 8'h9a;               // K
      8'h48: r.lo = 8'h9d;               // H
      8'h63: begin r.hi = 8'hd1; r.lo = 8'h81; end  // c
      8'h43: r.lo = 8'ha1;               // C
      8'h4d: r.lo = 8'h9c;               // M
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Continuation bytes that follow a lead byte: leading ones minus one.
  function automatic logic [2:0] lead_skip(input logic [7:0] c);
    logic [3:0] ones;
    logic       run;
    ones = 4'd0;
    run  = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && c[i]) begin
        ones = ones + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return 3'(ones - 4'd1);
  endfunction

endpackage

`default_nettype wire

/* rtl/uhs_front.sv */
// Front end: takes input items, tracks UTF-8 sequences and builds each output run.
`default_nettype none

module uhs_front #(
  parameter int unsigned RAND_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [uhs_pkg::PROB_W-1:0]  cfg_data,
  input  wire logic                        accept,
  input  wire logic [7:0]                  in_byte,
  input  wire logic [RAND_BITS-1:0]        rand_space,
  input  wire logic [RAND_BITS-1:0]        rand_question,
  input  wire logic [RAND_BITS-1:0]        rand_letter,
  output uhs_pkg::run_t                    run
);
  import uhs_pkg::*;

  localparam int unsigned CMP_W = RAND_BITS + PROB_W;

  logic [PROB_W-1:0] prob_space;
  logic [PROB_W-1:0] prob_question;
  logic [PROB_W-1:0] prob_letter;
  logic [2:0]        skip_count;
  logic [2:0]        skip_count_next;

  logic    fire_space, fire_question, fire_letter;
  letter_t look;
  logic [39:0] tail;
  logic [2:0]  tail_last;

  // A choice fires when r * 2^16 < prob * 2^RAND_BITS.
  assign fire_space    = {1'b0, rand_space, {PROB_FRAC{1'b0}}}
                         < CMP_W'({prob_space, {RAND_BITS{1'b0}}});
  assign fire_question = {1'b0, rand_question, {PROB_FRAC{1'b0}}}
                         < CMP_W'({prob_question, {RAND_BITS{1'b0}}});
  assign fire_letter   = {1'b0, rand_letter, {PROB_FRAC{1'b0}}}
                         < CMP_W'({prob_letter, {RAND_BITS{1'b0}}});

  assign look = letter_lookup(in_byte);

  always_comb begin
    if (in_byte == SEMICOLON && fire_question) begin
      tail      = {24'd0, GREEK_Q1, GREEK_Q0};
      tail_last = 3'd1;
    end else if (look.hit && fire_letter) begin
      if (in_byte == LATIN_A) begin
        tail      = {look.lo, look.hi, ZWSP_B2, ZWSP_B1, ZWSP_B0};
        tail_last = 3'd4;
      end else begin
        tail      = {24'd0, look.lo, look.hi};
        tail_last = 3'd1;
      end
    end else begin
      tail      = {32'd0, in_byte};
      tail_last = 3'd0;
    end
  end

  always_comb begin
    skip_count_next = skip_count;
    run.bytes       = {56'd0, in_byte};
    run.last_idx    = 3'd0;
    if (skip_count != 3'd0) begin
      skip_count_next = skip_count - 3'd1;
    end else if ((in_byte & HIGH_BIT) != 8'd0) begin
      skip_count_next = lead_skip(in_byte);
    end else if (fire_space) begin
      run.bytes    = {tail, ZWSP_B2, ZWSP_B1, ZWSP_B0};
      run.last_idx = tail_last + 3'd3;
    end else begin
      run.bytes    = {24'd0, tail};
      run.last_idx = tail_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prob_space    <= '0;
      prob_question <= '0;
      prob_letter   <= '0;
      skip_count    <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROB_SPACE:    prob_space    <= cfg_data;
          CFG_PROB_QUESTION: prob_question <= cfg_data;
          CFG_PROB_LETTER:   prob_letter   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        skip_count <= skip_count_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/uhs_queue.sv */
// Two-entry queue of output runs between the front end and the byte emitter.
`default_nettype none

module uhs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire uhs_pkg::run_t push_run,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output uhs_pkg::run_t      head_run
);
  import uhs_pkg::*;

  run_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count[1];
  assign head_valid = count != 2'd0;
  assign head_run   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/uhs_back.sv */
// Back end: walks the head run one byte a cycle into the output register, while out_ready lets it load.
`default_nettype none

module uhs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire uhs_pkg::run_t head_run,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import uhs_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_last;

  assign load    = !out_valid || out_ready;
  assign at_last = idx == head_run.last_idx;
  assign pop     = head_valid && load && at_last;

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte <= head_run.bytes[idx*8 +: 8];
      out_last <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= at_last ? '0 : idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8_homoglyph_substituter.sv */
// Top level of the UTF-8 homoglyph substituter.
//
//   group   dir  handshake          payload
//   s_axis  in   s_tvalid/s_tready  s_tdata: in_byte, rand_space, rand_question, rand_letter
//   m_axis  out  m_tvalid/m_tready  m_tdata: out_byte; m_tlast: last_of_run
//   cfg     in   cfg_we             cfg_index, cfg_data (17-bit probabilities)
//
// Each input item yields a run of 1 to 8 output bytes, one byte per cycle while m_tready is
// high. Plain bytes flow at one item per cycle on that condition; a run of several bytes
// holds the output side until its last byte is out. The two-entry run queue takes one more
// item while a run drains, then s_tready drops until the run's last byte moves to the output.
// Each accepted item goes into the run queue and from there into the output register.
// Reset is synchronous and clears the probabilities, the UTF-8 skip count and the queue.
`default_nettype none

module utf8_homoglyph_substituter #(
  parameter int unsigned RAND_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [uhs_pkg::PROB_W-1:0]            cfg_data,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // in_byte, rand_space, rand_question, rand_letter from bit 0 up
  input  wire logic [((8+3*RAND_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // out_byte
  output logic [7:0]                                 m_tdata,
  output logic                                       m_tlast
);
  import uhs_pkg::*;

  logic accept;
  logic full;
  logic pop;
  logic head_valid;
  run_t new_run;
  run_t head_run;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  uhs_front #(.RAND_BITS(RAND_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .in_byte       (s_tdata[7:0]),
    .rand_space    (s_tdata[8 +: RAND_BITS]),
    .rand_question (s_tdata[8+RAND_BITS +: RAND_BITS]),
    .rand_letter   (s_tdata[8+2*RAND_BITS +: RAND_BITS]),
    .run           (new_run)
  );

  uhs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_run   (new_run),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  uhs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

`default_nettype wire

/* dv/utf8_homoglyph_substituter_tb.sv */
// Self-checking testbench of the UTF-8 homoglyph substituter, with predictor and scoreboard.
`timescale 1ns / 100ps

module utf8_homoglyph_substituter_tb;
  import uhs_pkg::*;

  localparam int unsigned RAND_BITS   = 16;
  localparam int unsigned TDATA_W     = ((8 + 3 * RAND_BITS + 7) / 8) * 8;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  localparam logic [16:0] PROB_ONE    = 17'h10000;
  localparam logic [16:0] PROB_HALF   = 17'h08000;
  localparam logic [16:0] PROB_MAX    = 17'h1ffff;

  // Packed so that text_byte lands in the lowest bits of s_tdata.
  typedef struct packed {
    logic [15:0] rand_letter;
    logic [15:0] rand_question;
    logic [15:0] rand_space;
    logic [7:0]  text_byte;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_beat_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [PROB_W-1:0]  cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tlast;

  // Shadow of the block's registers and UTF-8 state.
  logic [16:0] zwsp_prob = '0;
  logic [16:0] greek_prob = '0;
  logic [16:0] cyr_prob = '0;
  logic [2:0]  skip_left = '0;

  text_item_t pending_items[$];
  out_beat_t  expected_beats[$];
  text_item_t in_flight;
  bit         offering = 1'b0;
  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;
  int         src_wait = 0;
  int         sink_wait = 0;
  int         src_gap_max = 0;
  int         sink_max = 0;
  int         long_hold = 0;
  int         idle_cycles = 0;
  int         err_count = 0;
  int         items_in = 0;
  int         beats_checked = 0;
  int         lead_cnt = 0;
  int         zwsp_cnt = 0;
  int         greek_cnt = 0;
  int         cyr_cnt = 0;
  int         settings_cnt = 0;
  string      latin_set = "aAeEToOxXyKHcCM";

  utf8_homoglyph_substituter #(
    .RAND_BITS(RAND_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A choice fires when the 0.16 random word is below the 1.16 probability.
  function automatic bit chance_hit(input logic [15:0] r, input logic [16:0] p);
    return {1'b0, r} < p;
  endfunction

  // Returns {hit, first byte, second byte} of the Cyrillic look-alike.
  function automatic logic [16:0] cyrillic_pair(input logic [7:0] c);
    case (c)
      "a": return {1'b1, 16'hd0b0};
      "A": return {1'b1, 16'hd090};
      "e": return {1'b1, 16'hd0b5};
      "E": return {1'b1, 16'hd095};
      "T": return {1'b1, 16'hd0a2};
      "o": return {1'b1, 16'hd0be};
      "O": return {1'b1, 16'hd09e};
      "x": return {1'b1, 16'hd185};
      "X": return {1'b1, 16'hd0a5};
      "y": return {1'b1, 16'hd183};
      "K": return {1'b1, 16'hd09a};
      "H": return {1'b1, 16'hd09d};
      "c": return {1'b1, 16'hd181};
      "C": return {1'b1, 16'hd0a1};
      "M": return {1'b1, 16'hd09c};
      default: return 17'h0;
    endcase
  endfunction

  task automatic predict_run(input text_item_t it);
    logic [7:0]  run_q[$];
    logic [3:0]  ones;
    logic [7:0]  sh;
    logic [16:0] cyr;
    out_beat_t   beat;
    cyr = cyrillic_pair(it.text_byte);
    if (skip_left != 3'd0) begin
      skip_left = skip_left - 3'd1;
      run_q.push_back(it.text_byte);
    end else if (it.text_byte[7]) begin
      ones = 4'd0;
      sh   = it.text_byte;
      while (ones < 4'd8 && sh[7]) begin
        ones = ones + 4'd1;
        sh   = sh << 1;
      end
      skip_left = 3'(ones - 4'd1);
      lead_cnt++;
      run_q.push_back(it.text_byte);
    end else begin
      if (chance_hit(it.rand_space, zwsp_prob)) begin
        run_q.push_back(ZWSP_B0);
        run_q.push_back(ZWSP_B1);
        run_q.push_back(ZWSP_B2);
        zwsp_cnt++;
      end
      if (it.text_byte == SEMICOLON && chance_hit(it.rand_question, greek_prob)) begin
        run_q.push_back(GREEK_Q0);
        run_q.push_back(GREEK_Q1);
        greek_cnt++;
      end else if (cyr[16] && chance_hit(it.rand_letter, cyr_prob)) begin
        // The look-alike of a small a brings its own zero-width space.
        if (it.text_byte == LATIN_A) begin
          run_q.push_back(ZWSP_B0);
          run_q.push_back(ZWSP_B1);
          run_q.push_back(ZWSP_B2);
        end
        run_q.push_back(cyr[15:8]);
        run_q.push_back(cyr[7:0]);
        cyr_cnt++;
      end else begin
        run_q.push_back(it.text_byte);
      end
    end
    foreach (run_q[i]) begin
      beat.out_byte = run_q[i];
      beat.last     = (i == run_q.size() - 1);
      expected_beats.push_back(beat);
    end
  endtask

  // Source side: one item offered at a time, with a random gap after each accept.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        offering = 1'b0;
        src_wait = $urandom_range(0, src_gap_max);
      end
      if (!offering) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (pending_items.size() > 0) begin
          in_flight = pending_items.pop_front();
          offering  = 1'b1;
          s_tdata  <= in_flight;
        end
      end
      s_tvalid <= offering;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      skip_left = 3'd0;
    end else if (s_tvalid && s_tready) begin
      predict_run(in_flight);
      in_taken = 1'b1;
      items_in++;
    end
  end

  // Sink side: random stall after each output item, plus an occasional long hold.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        sink_wait = $urandom_range(0, sink_max);
      end
      if (long_hold > 0) begin
        long_hold--;
        m_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      out_taken = 1'b1;
      if (expected_beats.size() == 0) begin
        err_count++;
        $display("%0t: output item with nothing expected: byte %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (m_tdata !== want.out_byte) begin
          err_count++;
          $display("%0t: out_byte expected %h, actual %h", $time, want.out_byte, m_tdata);
        end
        if (m_tlast !== want.last) begin
          err_count++;
          $display("%0t: last_of_run expected %b, actual %b", $time, want.last, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d bytes still expected",
               $time, idle_cycles, expected_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_prob(input logic [1:0] idx, input logic [16:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_PROB_SPACE:    zwsp_prob  = value;
      CFG_PROB_QUESTION: greek_prob = value;
      CFG_PROB_LETTER:   cyr_prob   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || offering || expected_beats.size() > 0) begin
      @(posedge clk);
    end
    // Leave a margin after the last expected byte.
    repeat (6) @(posedge clk);
  endtask

  task automatic queue_item(input logic [7:0] b, input logic [15:0] rs, input logic [15:0] rq,
                            input logic [15:0] rl);
    text_item_t it;
    it.text_byte     = b;
    it.rand_space    = rs;
    it.rand_question = rq;
    it.rand_letter   = rl;
    pending_items.push_back(it);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_item(b, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Mostly text with letters, semicolons and whole UTF-8 sequences; some noise
  // and sequences cut short.
  task automatic queue_random_text(input int n);
    int         made;
    int         kind;
    int         cont;
    int         sent;
    logic [7:0] lead;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 38) begin
        queue_byte(8'(latin_set[$urandom_range(0, 14)]));
        made++;
      end else if (kind < 52) begin
        queue_byte(SEMICOLON);
        made++;
      end else if (kind < 74) begin
        queue_byte(8'($urandom_range(0, 127)));
        made++;
      end else if (kind < 94) begin
        cont = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 7);
        lead = ~(8'hff >> (cont + 1)) | (8'($urandom) & (8'h7f >> (cont + 1)));
        sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cont) : cont;
        queue_byte(lead);
        for (int k = 0; k < sent; k++) begin
          queue_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
        made += 1 + sent;
      end else begin
        queue_byte(8'($urandom_range(0, 255)));
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [16:0] sp, input logic [16:0] qp, input logic [16:0] lp,
                           input int gmax, input int smax, input int hold, input int n);
    wait_drained();
    write_prob(CFG_PROB_SPACE, sp);
    write_prob(CFG_PROB_QUESTION, qp);
    write_prob(CFG_PROB_LETTER, lp);
    settings_cnt++;
    @(posedge clk);
    src_gap_max = gmax;
    sink_max    = smax;
    long_hold   = hold;
    queue_random_text(n);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: nothing may fire even with the lowest random words.
    queue_item("a", 16'h0000, 16'h0000, 16'h0000);
    queue_item(SEMICOLON, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();
    settings_cnt++;

    // Probability of one: every choice fires, even with the highest words.
    write_prob(CFG_PROB_SPACE, PROB_ONE);
    write_prob(CFG_PROB_QUESTION, PROB_ONE);
    write_prob(CFG_PROB_LETTER, PROB_ONE);
    settings_cnt++;
    queue_item("a", 16'hffff, 16'hffff, 16'hffff);
    queue_item(SEMICOLON, 16'hffff, 16'hffff, 16'hffff);
    queue_item("M", 16'hffff, 16'hffff, 16'hffff);
    queue_item("y", 16'hffff, 16'hffff, 16'hffff);
    queue_item(8'h00, 16'hffff, 16'hffff, 16'hffff);
    queue_item(8'h7f, 16'hffff, 16'hffff, 16'hffff);
    // An all-ones lead byte is followed by seven raw bytes of any kind.
    queue_item(8'hff, 16'hffff, 16'hffff, 16'hffff);
    queue_item("a", 16'h0000, 16'h0000, 16'h0000);
    queue_item(8'hbf, 16'h0000, 16'h0000, 16'h0000);
    queue_item(SEMICOLON, 16'h0000, 16'h0000, 16'h0000);
    queue_item(8'h80, 16'h0000, 16'h0000, 16'h0000);
    queue_item(8'h00, 16'h0000, 16'h0000, 16'h0000);
    queue_item(8'hc0, 16'h0000, 16'h0000, 16'h0000);
    queue_item(8'hff, 16'h0000, 16'h0000, 16'h0000);
    // A stray continuation byte as a lead sets no skip.
    queue_item(8'h80, 16'hffff, 16'hffff, 16'hffff);
    queue_item("Z", 16'hffff, 16'hffff, 16'hffff);
    wait_drained();

    // One half: the compare boundary on each random word.
    write_prob(CFG_PROB_SPACE, PROB_HALF);
    write_prob(CFG_PROB_QUESTION, PROB_HALF);
    write_prob(CFG_PROB_LETTER, PROB_HALF);
    write_prob(CFG_UNUSED, PROB_MAX);
    settings_cnt++;
    queue_item(SEMICOLON, 16'h8000, 16'h7fff, 16'h0000);
    queue_item(SEMICOLON, 16'h8000, 16'h8000, 16'h0000);
    queue_item("a", 16'h8000, 16'h0000, 16'h7fff);
    queue_item("a", 16'h8000, 16'h0000, 16'h8000);
    queue_item("b", 16'h7fff, 16'h0000, 16'h0000);
    queue_item("K", 16'h0000, 16'hffff, 16'h0000);

    run_phase(PROB_MAX, PROB_MAX, PROB_MAX, 11, 11, 0, 55);
    run_phase(17'h0, 17'h0, 17'h0, 0, 0, 0, 55);
    // The sink holds off long enough for the block to fill up and stall its input.
    run_phase(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
              17'($urandom_range(0, 65536)), 0, 11, 300, 55);
    run_phase(17'h04000, 17'h0c000, PROB_HALF, 11, 0, 0, 55);
    run_phase(PROB_ONE, 17'h0, 17'h1, 11, 11, 0, 55);
    run_phase(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
              17'($urandom_range(0, 131071)), 3, 3, 0, 55);
    wait_drained();

    $display("Covered %0d input items and %0d output bytes under %0d register settings,",
             items_in, beats_checked, settings_cnt);
    $display("with %0d lead bytes, %0d spaces, %0d Greek marks and %0d Cyrillic letters.",
             lead_cnt, zwsp_cnt, greek_cnt, cyr_cnt);
    if (err_count == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
